// ===== src/irm_pkg.sv =====
// Package: command and register codes, sizes and the port-write record of the relay mapper.
`default_nettype none

package irm_pkg;

	// Input lines per input chip and bits per output port
	localparam int LINES_PER_CHIP = 16;
	localparam int PORT_BITS      = 8;
	localparam int NUM_OUTPUTS    = 64;

	// Item commands
	typedef enum logic [1:0] {
		CMD_SCAN  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_DRIVE = 2'd2
	} cmd_t;

	// Configuration register indexes
	typedef enum logic {
		REG_ACTIVE = 1'b0,
		REG_TOGGLE = 1'b1
	} reg_t;

	// One port write waiting to go out
	typedef struct packed {
		logic [1:0]           chip;
		logic                 side;
		logic [PORT_BITS-1:0] data;
	} res_t;

endpackage

`default_nettype wire

// ===== src/irm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module irm_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/input_to_relay_mapper.sv =====
// Top level: maps scanned input words onto relay port writes, one input line per cycle.
`default_nettype none

// Timing for users: a scan item keeps busy high while it steps through its input
// lines (16 lines, stepped one bit a cycle through the relation table RAM), then in
// a drain state for the RAM's registered read of the last line and in a flush state
// to send the final port write. A direct drive keeps busy high for the drain and
// flush states only. A relation load, an unknown command and a scan of a missing
// chip never raise busy. Each port write appears on strobe for one cycle and cannot
// be held off by the receiver; the write that carries last arrives as busy falls,
// and a new item may be started in that same cycle.
module input_to_relay_mapper #(
	parameter int NUM_CHIPS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [1:0]  chip,
	input  wire logic [15:0] word,
	input  wire logic [5:0]  entry_index,
	input  wire logic [5:0]  target,
	input  wire logic        level,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	// port writes
	output logic             strobe,
	output logic [1:0]       out_chip,
	output logic             out_side,
	output logic [7:0]       out_byte,
	output logic             last
);

	localparam int RAM_DEPTH = NUM_CHIPS * irm_pkg::LINES_PER_CHIP;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int NUM_PORTS = NUM_CHIPS * 2;
	localparam int LW        = irm_pkg::LINES_PER_CHIP;
	localparam int PB        = irm_pkg::PORT_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	state_t state_q;

	logic [irm_pkg::NUM_OUTPUTS-1:0] active_q;
	logic [irm_pkg::NUM_OUTPUTS-1:0] toggle_q;

	logic [LW-1:0] prev_q  [NUM_CHIPS];
	logic [PB-1:0] ports_q [NUM_PORTS];

	// line shifters
	logic [LW-1:0] diff_q;
	logic [LW-1:0] word_q;
	logic [1:0]    chip_q;
	logic [3:0]    cnt_q;

	// line step stage, aligned with the relation read
	logic          vld_s1;
	logic          edge_s1;
	logic          lvl_s1;
	logic          direct_s1;
	logic [5:0]    dtgt_s1;

	// pending port write and output registers
	logic            pend_vld_q;
	irm_pkg::res_t   pend_q;
	logic            strobe_q;
	irm_pkg::res_t   out_q;
	logic            last_q;

	logic            accept;
	logic            chip_in_ok;
	logic [LW-1:0]   prev_sel;
	logic [5:0]      rel_rdata;
	logic            ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [RAM_AW-1:0] ram_raddr;

	logic [5:0]      tgt_s1;
	logic [2:0]      oport;
	logic            out_chip_ok;
	logic [PB-1:0]   cur_byte;
	logic [PB-1:0]   bit_mask;
	logic [PB-1:0]   new_byte;
	logic            wr_now;

	assign accept     = start && !busy;
	assign busy       = (state_q != ST_IDLE);
	assign chip_in_ok = ({1'b0, chip} < 3'(NUM_CHIPS));

	// Select the stored word of the scanned chip
	always_comb begin
		prev_sel = '0;
		for (int c = 0; c < NUM_CHIPS; c++) begin
			if (chip == 2'(c)) begin
				prev_sel = prev_q[c];
			end
		end
	end

	// Relation table: written by load items, read one line per scan cycle
	assign ram_we    = accept && (irm_pkg::cmd_t'(cmd) == irm_pkg::CMD_LOAD) &&
	                   (7'(entry_index) < 7'(RAM_DEPTH));
	assign ram_waddr = RAM_AW'(entry_index);
	assign ram_raddr = RAM_AW'({chip_q, cnt_q});

	irm_ram #(
		.WIDTH (6),
		.DEPTH (RAM_DEPTH)
	) u_rel (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (target),
		.raddr (ram_raddr),
		.rdata (rel_rdata)
	);

	// Work out the port write of the current line or direct drive
	always_comb begin
		tgt_s1      = direct_s1 ? dtgt_s1 : rel_rdata;
		oport       = tgt_s1[5:3];
		out_chip_ok = ({1'b0, tgt_s1[5:4]} < 3'(NUM_CHIPS));
		cur_byte    = '0;
		for (int p = 0; p < NUM_PORTS; p++) begin
			if (oport == 3'(p)) begin
				cur_byte = ports_q[p];
			end
		end
		bit_mask = PB'(1) << tgt_s1[2:0];
		wr_now   = vld_s1 && edge_s1 && out_chip_ok && active_q[tgt_s1] &&
		           (!toggle_q[tgt_s1] || lvl_s1);
		if (toggle_q[tgt_s1]) begin
			new_byte = cur_byte ^ bit_mask;
		end else if (lvl_s1) begin
			new_byte = cur_byte | bit_mask;
		end else begin
			new_byte = cur_byte & ~bit_mask;
		end
	end

	// Hold the last word seen on each input chip
	for (genvar c = 0; c < NUM_CHIPS; c++) begin : g_prev
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				prev_q[c] <= '0;
			end else if (accept && (irm_pkg::cmd_t'(cmd) == irm_pkg::CMD_SCAN) &&
			             (chip == 2'(c))) begin
				prev_q[c] <= word;
			end
		end
	end

	// Update output port bytes on each port write
	for (genvar p = 0; p < NUM_PORTS; p++) begin : g_port
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ports_q[p] <= '0;
			end else if (wr_now && (oport == 3'(p))) begin
				ports_q[p] <= new_byte;
			end
		end
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			toggle_q <= '0;
		end else if (cfg_we) begin
			case (irm_pkg::reg_t'(cfg_index))
				irm_pkg::REG_ACTIVE: active_q <= cfg_data;
				irm_pkg::REG_TOGGLE: toggle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: step lines, hold one write back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			diff_q     <= '0;
			word_q     <= '0;
			chip_q     <= '0;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			edge_s1    <= 1'b0;
			lvl_s1     <= 1'b0;
			direct_s1  <= 1'b0;
			dtgt_s1    <= '0;
			pend_vld_q <= 1'b0;
			pend_q     <= '0;
			strobe_q   <= 1'b0;
			out_q      <= '0;
			last_q     <= 1'b0;
		end else begin
			strobe_q  <= 1'b0;
			vld_s1    <= 1'b0;
			direct_s1 <= 1'b0;

			// queue the new write, release the one before it
			if (wr_now) begin
				if (pend_vld_q) begin
					strobe_q <= 1'b1;
					out_q    <= pend_q;
					last_q   <= 1'b0;
				end
				pend_q.chip <= oport[2:1];
				pend_q.side <= oport[0];
				pend_q.data <= new_byte;
				pend_vld_q  <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (irm_pkg::cmd_t'(cmd))
							irm_pkg::CMD_SCAN: begin
								if (chip_in_ok) begin
									diff_q  <= word ^ prev_sel;
									word_q  <= word;
									chip_q  <= chip;
									cnt_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							irm_pkg::CMD_DRIVE: begin
								vld_s1    <= 1'b1;
								edge_s1   <= 1'b1;
								lvl_s1    <= level;
								direct_s1 <= 1'b1;
								dtgt_s1   <= target;
								state_q   <= ST_DRAIN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					// advance one input line
					vld_s1  <= 1'b1;
					edge_s1 <= diff_q[0];
					lvl_s1  <= word_q[0];
					diff_q  <= diff_q >> 1;
					word_q  <= word_q >> 1;
					cnt_q   <= cnt_q + 4'd1;
					if (cnt_q == 4'(LW - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					// send the held write as the final one
					if (pend_vld_q) begin
						strobe_q <= 1'b1;
						out_q    <= pend_q;
						last_q   <= 1'b1;
					end
					pend_vld_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe   = strobe_q;
	assign out_chip = out_q.chip;
	assign out_side = out_q.side;
	assign out_byte = out_q.data;
	assign last     = last_q;

	// No write may be held back once the block is idle
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !pend_vld_q)
		else $error("port write still pending while idle");

	// A write without last always has a later write of the same item behind it
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final port write outside an item");

	// The final write of an item is never followed at once by another write
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("port write right after final write");

	// A scan of a present chip occupies the block
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == irm_pkg::CMD_SCAN) && chip_in_ok |=> busy)
		else $error("scan accepted but block not busy");

	// Line steps only come from the scan or a direct drive
	a_step_src: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN))
		else $error("line step outside scan");

endmodule

`default_nettype wire

// ===== verif/relay_write_checker.sv =====
// Checker: predicts relay port writes from accepted transfers and compares them with the block.
module relay_write_checker #(
	parameter int NUM_CHIPS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [1:0]  chip,
	input  wire logic [15:0] word,
	input  wire logic [5:0]  entry_index,
	input  wire logic [5:0]  target,
	input  wire logic        level,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        strobe,
	input  wire logic [1:0]  out_chip,
	input  wire logic        out_side,
	input  wire logic [7:0]  out_byte,
	input  wire logic        last,
	output int               pending,
	output int               fails
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		irm_pkg::res_t wr;
		logic last;
	} port_write_t;

	// Predicted block state
	logic [63:0]   active_relays;
	logic [63:0]   toggle_outputs;
	logic [15:0]   scanned_levels [4];
	logic [7:0]    relay_ports [8];
	logic [5:0]    relation [64];

	port_write_t   expected_port_writes[$];
	port_write_t   item_writes[$];

	initial fails = 0;

	task automatic report(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		fails++;
	endtask

	// Apply one edge or direct drive to a relay and note the port write it causes
	task automatic drive_relay(input logic [5:0] tgt, input logic lvl);
		logic [1:0]  ochip;
		logic        oside;
		int          idx;
		logic [7:0]  bit_mask;
		port_write_t w;
		ochip = tgt[5:4];
		if (int'(ochip) >= NUM_CHIPS || !active_relays[tgt])
			return;
		oside = tgt[3];
		idx = int'(ochip) * 2 + int'(oside);
		bit_mask = 8'b1 << tgt[2:0];
		if (toggle_outputs[tgt]) begin
			if (!lvl)
				return;
			relay_ports[idx] ^= bit_mask;
		end else if (lvl) begin
			relay_ports[idx] |= bit_mask;
		end else begin
			relay_ports[idx] &= ~bit_mask;
		end
		w.wr.chip = ochip;
		w.wr.side = oside;
		w.wr.data = relay_ports[idx];
		w.last = 1'b0;
		item_writes.push_back(w);
	endtask

	// Work out every port write that one accepted transfer causes, in order
	task automatic predict_port_writes(input logic [1:0] op, input logic [1:0] ch,
			input logic [15:0] levels, input logic [5:0] ei, input logic [5:0] tg,
			input logic lv);
		logic [15:0] changed;
		int          line;
		port_write_t w;
		item_writes.delete();
		case (irm_pkg::cmd_t'(op))
			irm_pkg::CMD_SCAN: begin
				if (int'(ch) < NUM_CHIPS) begin
					changed = levels ^ scanned_levels[ch];
					for (int i = 0; i < irm_pkg::LINES_PER_CHIP; i++) begin
						if (changed[i]) begin
							line = (int'(ch) * irm_pkg::LINES_PER_CHIP + i) %
								irm_pkg::NUM_OUTPUTS;
							drive_relay(relation[line], levels[i]);
						end
					end
					scanned_levels[ch] = levels;
				end
			end
			irm_pkg::CMD_LOAD: relation[ei] = tg;
			irm_pkg::CMD_DRIVE: drive_relay(tg, lv);
			default: ;
		endcase
		for (int n = 0; n < item_writes.size(); n++) begin
			w = item_writes[n];
			w.last = (n == item_writes.size() - 1);
			expected_port_writes.push_back(w);
		end
	endtask

	// Compare one port write with the oldest expectation
	task automatic check_port_write();
		port_write_t e;
		if (expected_port_writes.size() == 0) begin
			report($sformatf("port write chip %0d side %0d byte %02h with nothing expected",
				out_chip, out_side, out_byte));
			return;
		end
		e = expected_port_writes.pop_front();
		if (out_chip !== e.wr.chip)
			report($sformatf("out_chip %0d, expected %0d", out_chip, e.wr.chip));
		if (out_side !== e.wr.side)
			report($sformatf("out_side %0d, expected %0d", out_side, e.wr.side));
		if (out_byte !== e.wr.data)
			report($sformatf("out_byte %02h, expected %02h", out_byte, e.wr.data));
		if (last !== e.last)
			report($sformatf("last %0d, expected %0d", last, e.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_relays = '0;
			toggle_outputs = '0;
			for (int i = 0; i < 4; i++)
				scanned_levels[i] = '0;
			for (int i = 0; i < 8; i++)
				relay_ports[i] = '0;
			for (int i = 0; i < 64; i++)
				relation[i] = '0;
			expected_port_writes.delete();
			pending <= 0;
		end else begin
			// check results first: a new transfer may start in the cycle of the last write
			if (strobe)
				check_port_write();
			if (cfg_we) begin
				case (irm_pkg::reg_t'(cfg_index))
					irm_pkg::REG_ACTIVE: active_relays = cfg_data;
					irm_pkg::REG_TOGGLE: toggle_outputs = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				predict_port_writes(cmd, chip, word, entry_index, target, level);
			pending <= expected_port_writes.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: drives command and configuration transfers into the relay mapper and gives the verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         NUM_CHIPS   = 4;
	localparam int         CYCLE_LIMIT = 100000;
	localparam int         SETTLE_CYCLES = 20;
	localparam int         PHASE_ITEMS = 79;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = irm_pkg::CMD_SCAN;
	logic [1:0]  chip = '0;
	logic [15:0] word = '0;
	logic [5:0]  entry_index = '0;
	logic [5:0]  target = '0;
	logic        level = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = irm_pkg::REG_ACTIVE;
	logic [63:0] cfg_data = '0;
	logic        strobe;
	logic [1:0]  out_chip;
	logic        out_side;
	logic [7:0]  out_byte;
	logic        last;

	int          pending;
	int          fails;
	int          cycle_count = 0;
	bit          idling_on = 1'b1;

	// Stimulus bookkeeping: last scanned levels and relation entries loaded so far
	logic [15:0] scan_levels [4] = '{default: '0};
	logic [15:0] loaded_lines [4] = '{default: '0};

	input_to_relay_mapper #(.NUM_CHIPS(NUM_CHIPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.cmd(cmd), .chip(chip), .word(word), .entry_index(entry_index),
		.target(target), .level(level),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .out_chip(out_chip), .out_side(out_side),
		.out_byte(out_byte), .last(last)
	);

	relay_write_checker #(.NUM_CHIPS(NUM_CHIPS)) write_check (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.cmd(cmd), .chip(chip), .word(word), .entry_index(entry_index),
		.target(target), .level(level),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .out_chip(out_chip), .out_side(out_side),
		.out_byte(out_byte), .last(last),
		.pending(pending), .fails(fails)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		if (!idling_on || $urandom_range(0, 9) >= 3)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	// Only lines with a loaded relation entry may change level
	function automatic logic [15:0] masked_scan(input logic [1:0] ch, input logic [15:0] want);
		return scan_levels[ch] ^ ((scan_levels[ch] ^ want) & loaded_lines[ch]);
	endfunction

	// Present one command and hold it until the transfer happens
	task automatic send_item(input logic [1:0] op, input logic [1:0] ch, input logic [15:0] w,
			input logic [5:0] ei, input logic [5:0] tg, input logic lv);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		chip <= ch;
		word <= w;
		entry_index <= ei;
		target <= tg;
		level <= lv;
		do @(posedge clk); while (busy);
		if (op == irm_pkg::CMD_SCAN)
			scan_levels[ch] = w;
		else if (op == irm_pkg::CMD_LOAD)
			loaded_lines[ei[5:4]][ei[3:0]] = 1'b1;
	endtask

	task automatic send_scan(input logic [1:0] ch, input logic [15:0] want);
		send_item(irm_pkg::CMD_SCAN, ch, masked_scan(ch, want), 6'($urandom), 6'($urandom),
			1'($urandom));
	endtask

	task automatic send_load(input logic [5:0] ei, input logic [5:0] tg);
		send_item(irm_pkg::CMD_LOAD, 2'($urandom), 16'($urandom), ei, tg, 1'($urandom));
	endtask

	task automatic send_drive(input logic [5:0] tg, input logic lv);
		send_item(irm_pkg::CMD_DRIVE, 2'($urandom), 16'($urandom), 6'($urandom), tg, lv);
	endtask

	// Hold off until every expected write has come and the block is quiet
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_relay_modes(input logic [63:0] active, input logic [63:0] toggle);
		cfg_we <= 1'b1;
		cfg_index <= irm_pkg::REG_ACTIVE;
		cfg_data <= active;
		@(posedge clk);
		cfg_index <= irm_pkg::REG_TOGGLE;
		cfg_data <= toggle;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random command; ignored commands do not count toward the phase
	task automatic random_item(output bit counted);
		int          sel;
		logic [1:0]  ch;
		logic [15:0] flips;
		sel = $urandom_range(0, 99);
		counted = 1'b1;
		if (sel < 45) begin
			ch = 2'($urandom);
			flips = ($urandom_range(0, 3) == 0) ? (16'h1 << $urandom_range(0, 15))
				: 16'($urandom);
			send_scan(ch, scan_levels[ch] ^ flips);
		end else if (sel < 65) begin
			send_load(6'($urandom), 6'($urandom));
		end else if (sel < 90) begin
			send_drive(6'($urandom), 1'($urandom));
		end else begin
			send_item(CMD_UNKNOWN, 2'($urandom), 16'($urandom), 6'($urandom),
				6'($urandom), 1'($urandom));
			counted = 1'b0;
		end
	endtask

	initial begin
		logic [63:0] phase_active [5];
		logic [63:0] phase_toggle [5];
		bit          counted;
		int          done;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: output 40 inactive, odd outputs toggle, even outputs follow
		set_relay_modes(64'hFFFF_FEFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
		send_load(6'd0, 6'd0);
		send_load(6'd1, 6'd63);
		send_load(6'd2, 6'd8);
		send_load(6'd15, 6'd40);
		send_load(6'd16, 6'd17);
		send_load(6'd48, 6'd0);
		send_load(6'd63, 6'd63);
		send_item(CMD_UNKNOWN, 2'($urandom), 16'($urandom), 6'($urandom), 6'($urandom),
			1'($urandom));
		send_scan(2'd0, 16'h0001);
		send_scan(2'd0, 16'h8007);
		send_scan(2'd0, 16'h0000);
		send_scan(2'd0, 16'h0000);
		send_scan(2'd1, 16'h0001);
		send_scan(2'd1, 16'h0000);
		send_scan(2'd3, 16'h8001);
		send_scan(2'd3, 16'h0000);
		send_drive(6'd0, 1'b1);
		send_drive(6'd0, 1'b0);
		send_drive(6'd63, 1'b1);
		send_drive(6'd63, 1'b1);
		send_drive(6'd63, 1'b0);
		send_drive(6'd40, 1'b1);
		send_drive(6'd17, 1'b1);

		// Random phases over several relay mode settings, extremes first
		phase_active[0] = '1;
		phase_toggle[0] = '0;
		phase_active[1] = '1;
		phase_toggle[1] = '1;
		phase_active[2] = '0;
		phase_toggle[2] = {$urandom, $urandom};
		phase_active[3] = {$urandom, $urandom};
		phase_toggle[3] = {$urandom, $urandom};
		phase_active[4] = {$urandom, $urandom} | {$urandom, $urandom};
		phase_toggle[4] = {$urandom, $urandom};
		for (int p = 0; p < 5; p++) begin
			settle();
			set_relay_modes(phase_active[p], phase_toggle[p]);
			idling_on = (p < 4);
			done = 0;
			while (done < PHASE_ITEMS) begin
				random_item(counted);
				if (counted)
					done++;
				// in phase 1, drain once in mid-phase as well
				if (p == 1 && done == PHASE_ITEMS / 2 && counted)
					settle();
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES + 5) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
